/* design/cmpg_pkg.sv */
package cmpg_pkg;

    localparam int unsigned INDEX_W   = 18;
    localparam int unsigned VALUE_W   = 30;
    localparam int unsigned MAX_INDEX = 262143;
    localparam int unsigned INDEX_TOP = (1 << INDEX_W) - 1;
    // effective limit, clipped to what term_index can hold
    localparam int unsigned LIMIT_INT = (MAX_INDEX > INDEX_TOP) ? INDEX_TOP : MAX_INDEX;
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = LIMIT_INT[INDEX_W-1:0];

    localparam logic [VALUE_W-1:0] MODULUS_RESET = 30'd998244353;

    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [VALUE_W-1:0] t_value;

endpackage

/* design/cmpg_in_if.sv */
interface cmpg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

/* design/cmpg_out_if.sv */
interface cmpg_out_if;
    logic               valid;
    logic               ready;
    cmpg_pkg::t_index   term_index;
    cmpg_pkg::t_value   term_value;
    logic               at_limit;

    modport source (output valid, output term_index, output term_value, output at_limit,
                    input ready);
    modport sink   (input valid, input term_index, input term_value, input at_limit,
                    output ready);
endinterface

/* design/catalan_mod_prime_generator.sv */
// Channel   Dir  Word                               Handshake
// i_in      in   restart                            valid/ready
// o_out     out  term_index, term_value, at_limit   valid/ready
// cfg       in   i_cfg_wdata (modulus)              i_cfg_we, no back-pressure
//
// Restart and limit words go from idle straight to the done state.
// An advance word runs a 30x31 multiply, a bit-serial reduction, an
// extended Euclid loop (shift-up / subtract-down), a second multiply
// and reduction.
// Reset is synchronous active low; clears state, index and valid, reloads the modulus.
// i_in.ready is high only while idle; a finished word waits in the
// output register, and the next word is accepted meanwhile.
module catalan_mod_prime_generator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    cmpg_in_if.sink                i_in,
    cmpg_out_if.source             o_out,
    input  logic                   i_cfg_we,
    input  logic [cmpg_pkg::VALUE_W-1:0] i_cfg_wdata
);

    localparam int ACC_W = 61;
    localparam int T_W   = 34;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_RED1, S_EUC_CHK, S_EUC_UP, S_EUC_DN,
        S_MUL2, S_RED2, S_FIX, S_DONE
    } t_state;

    t_state                    r_state;
    cmpg_pkg::t_value          r_modulus;
    cmpg_pkg::t_value          r_p;        // effective modulus for this word
    cmpg_pkg::t_index          r_idx;      // last_index
    cmpg_pkg::t_value          r_val;      // last_value
    cmpg_pkg::t_index          r_i;        // index being computed
    logic                      r_flag;

    // shared multiplier / reducer
    logic [ACC_W-1:0]          r_acc;
    cmpg_pkg::t_value          r_red;
    logic [5:0]                r_cnt;
    cmpg_pkg::t_value          r_v;        // first reduced product

    // extended Euclid
    cmpg_pkg::t_value          r_r0, r_r1, r_rem;
    logic [30:0]               r_d;
    logic signed [T_W-1:0]     r_t0, r_t1, r_nt, r_dt;
    logic [4:0]                r_k;
    logic                      r_neg;

    // output register
    logic                      r_out_valid;
    cmpg_pkg::t_index          r_out_index;
    cmpg_pkg::t_value          r_out_value;
    logic                      r_out_limit;

    // ---- combinational datapath ----
    logic [30:0]               mul_a;
    logic [30:0]               mul_b;
    logic [ACC_W-1:0]          mul_p;
    logic [30:0]               red_t;
    logic [30:0]               red_s;
    cmpg_pkg::t_value          red_n;
    logic                      up_ok;
    logic                      dn_ok;
    cmpg_pkg::t_value          n_rem;
    logic signed [T_W-1:0]     n_nt;
    logic signed [T_W-1:0]     t0_mag;
    logic [20:0]               four_i;
    cmpg_pkg::t_value          n_p;
    cmpg_pkg::t_value          fix_val;
    logic                      out_free;

    assign four_i = {1'b0, r_i, 2'b00} - 21'd2;
    assign t0_mag = r_t0[T_W-1] ? -r_t0 : r_t0;

    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = {1'b0, r_val};
            mul_b = {10'd0, four_i};
        end else begin
            mul_a = {1'b0, r_v};
            mul_b = (r_r0 == 30'd1) ? t0_mag[30:0] : 31'd0;
        end
    end
    assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

    // one bit of restoring reduction per cycle
    assign red_t = {r_red, r_acc[ACC_W-1]};
    assign red_s = red_t - {1'b0, r_p};
    assign red_n = (red_t >= {1'b0, r_p}) ? red_s[29:0] : red_t[29:0];

    assign up_ok = ({r_d, 1'b0} <= {2'b00, r_rem});
    assign dn_ok = (r_d <= {1'b0, r_rem});
    assign n_rem = dn_ok ? (r_rem - r_d[29:0]) : r_rem;
    assign n_nt  = dn_ok ? (r_nt - r_dt) : r_nt;

    assign n_p     = (r_modulus < 30'd2) ? 30'd1 : r_modulus;
    assign fix_val = (r_neg && (r_red != '0)) ? (r_p - r_red) : r_red;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.term_index  = r_out_index;
    assign o_out.term_value  = r_out_value;
    assign o_out.at_limit    = r_out_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= cmpg_pkg::MODULUS_RESET;
            r_idx       <= '0;
            r_val       <= 30'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            // in S_DONE the output register is reloaded below
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_p    <= n_p;
                        if (i_in.restart) begin
                            r_flag  <= 1'b0;
                            r_idx   <= '0;
                            r_val   <= (n_p == 30'd1) ? 30'd0 : 30'd1;
                            r_state <= S_DONE;
                        end else if (r_idx >= cmpg_pkg::INDEX_LIMIT) begin
                            r_flag  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_flag  <= 1'b0;
                            r_i     <= r_idx + 1'b1;
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_acc   <= mul_p;
                    r_red   <= '0;
                    r_cnt   <= 6'(ACC_W - 1);
                    // Euclid on (p, i+1); r_j == t_j * (i+1) mod p
                    r_r0    <= r_p;
                    r_r1    <= {11'd0, r_i + 19'd1};
                    r_t0    <= '0;
                    r_t1    <= T_W'(1);
                    r_state <= S_RED1;
                end
                S_RED1: begin
                    r_red <= red_n;
                    r_acc <= {r_acc[ACC_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_v     <= red_n;
                        r_state <= S_EUC_CHK;
                    end
                end
                S_EUC_CHK: begin
                    if (r_r1 == '0) begin
                        r_state <= S_MUL2;
                    end else begin
                        r_d     <= {1'b0, r_r1};
                        r_dt    <= r_t1;
                        r_rem   <= r_r0;
                        r_nt    <= r_t0;
                        r_k     <= '0;
                        r_state <= S_EUC_UP;
                    end
                end
                S_EUC_UP: begin
                    if (up_ok) begin
                        r_d  <= {r_d[29:0], 1'b0};
                        r_dt <= r_dt <<< 1;
                        r_k  <= r_k + 1'b1;
                    end else begin
                        r_state <= S_EUC_DN;
                    end
                end
                S_EUC_DN: begin
                    r_rem <= n_rem;
                    r_nt  <= n_nt;
                    if (r_k == '0) begin
                        r_r0    <= r_r1;
                        r_r1    <= n_rem;
                        r_t0    <= r_t1;
                        r_t1    <= n_nt;
                        r_state <= S_EUC_CHK;
                    end else begin
                        r_d  <= {1'b0, r_d[30:1]};
                        r_dt <= r_dt >>> 1;
                        r_k  <= r_k - 1'b1;
                    end
                end
                S_MUL2: begin
                    // gcd != 1 -> inverse taken as zero (multiplier input is zero)
                    r_acc   <= mul_p;
                    r_neg   <= (r_r0 == 30'd1) && r_t0[T_W-1];
                    r_red   <= '0;
                    r_cnt   <= 6'(ACC_W - 1);
                    r_state <= S_RED2;
                end
                S_RED2: begin
                    r_red <= red_n;
                    r_acc <= {r_acc[ACC_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_val   <= fix_val;
                    r_idx   <= r_i;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= r_idx;
                        r_out_value <= r_val;
                        r_out_limit <= r_flag;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
